@@ src/b64sd_pkg.sv @@
`default_nettype none

package b64sd_pkg;

    // padding character, stops decoding for the rest of the string
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // sextet code for a character outside the alphabet
    localparam logic [6:0] SEXTET_NONE = 7'd64;

    // one character request
    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } char_req_t;

    // one result request
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       text_done;
        logic       decode_ok;
    } result_req_t;

    // map an ascii code to its 6-bit value, or SEXTET_NONE
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        begin
            v = SEXTET_NONE;
            if (c inside {[8'h41 : 8'h5A]}) begin
                v = 7'(c - 8'h41);
            end else if (c inside {[8'h61 : 8'h7A]}) begin
                v = 7'(c - 8'h61 + 8'd26);
            end else if (c inside {[8'h30 : 8'h39]}) begin
                v = 7'(c - 8'h30 + 8'd52);
            end else if (c == 8'h2B) begin
                v = 7'd62;
            end else if (c == 8'h2F) begin
                v = 7'd63;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/base64_stream_decoder.sv @@
// Streaming Base64 decoder taking one character per request and giving exactly one result
// request per character, one character per cycle sustained unless a result is held back, with
// each result registered; a character is taken while a finished result waits as long as
// that result leaves in the same cycle. Characters outside the Base64 alphabet are skipped,
// the first '=' ends decoding until the end-of-text character, and leftover bits are dropped.
// A result carries a byte when the character completed one, and on the end-of-text character
// it reports whether the string produced any byte; the decoder then clears its state.
`default_nettype none

module base64_stream_decoder (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    output logic                        char_stall,
    input  wire b64sd_pkg::char_req_t   char_data,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output b64sd_pkg::result_req_t      result_data
);

    logic [5:0]             bit_residue_reg, bit_residue_next;
    logic [2:0]             bits_held_reg, bits_held_next;
    logic                   pad_seen_reg, pad_seen_next;
    logic                   any_byte_out_reg, any_byte_out_next;
    logic                   result_valid_reg, result_valid_next;
    b64sd_pkg::result_req_t result_data_reg, result_data_next;

    logic        accept;
    logic [6:0]  sextet;
    logic [2:0]  held;
    logic [5:0]  residue_masked;
    logic [11:0] acc;
    logic [3:0]  n;
    logic        emit;
    logic [7:0]  byte_val;

    // take a character unless a result is waiting and held back
    assign char_stall   = result_valid_reg && result_stall;
    assign accept       = char_valid && !char_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // sextet lookup and accumulator shift
    always_comb
    begin
        sextet         = b64sd_pkg::sextet_of(char_data.in_char);
        held           = (bits_held_reg == 3'd7) ? 3'd6 : bits_held_reg;
        residue_masked = bit_residue_reg & 6'(~(6'h3F << held));
        acc            = {residue_masked, sextet[5:0]};
        n              = 4'(held) + 4'd6;
        emit           = 1'b0;
        byte_val       = 8'h00;
        if (n >= 4'd8) begin
            n        = n - 4'd8;
            emit     = 1'b1;
            byte_val = 8'(acc >> n);
        end
    end

    // next state and result
    always_comb
    begin
        bit_residue_next  = bit_residue_reg;
        bits_held_next    = bits_held_reg;
        pad_seen_next     = pad_seen_reg;
        any_byte_out_next = any_byte_out_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_data_next  = result_data_reg;
        if (accept) begin
            result_data_next.byte_valid = 1'b0;
            result_data_next.out_byte   = 8'h00;
            if (!pad_seen_reg) begin
                if (char_data.in_char == b64sd_pkg::PAD_CHAR) begin
                    pad_seen_next = 1'b1;
                end else if (sextet != b64sd_pkg::SEXTET_NONE) begin
                    bit_residue_next = 6'(acc) & 6'(~(6'h3F << n));
                    bits_held_next   = n[2:0];
                    if (emit) begin
                        result_data_next.byte_valid = 1'b1;
                        result_data_next.out_byte   = byte_val;
                        any_byte_out_next           = 1'b1;
                    end
                end
            end
            result_data_next.text_done = char_data.end_of_text;
            result_data_next.decode_ok = char_data.end_of_text && any_byte_out_next;
            result_valid_next          = 1'b1;
            // end of string returns to the reset state
            if (char_data.end_of_text) begin
                bit_residue_next  = 6'd0;
                bits_held_next    = 3'd0;
                pad_seen_next     = 1'b0;
                any_byte_out_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bit_residue_reg  <= 6'd0;
            bits_held_reg    <= 3'd0;
            pad_seen_reg     <= 1'b0;
            any_byte_out_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            bit_residue_reg  <= bit_residue_next;
            bits_held_reg    <= bits_held_next;
            pad_seen_reg     <= pad_seen_next;
            any_byte_out_reg <= any_byte_out_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_data_reg <= result_data_next;
    end

endmodule

`default_nettype wire

@@ src/b64sd_checker.sv @@
`default_nettype none

module b64sd_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   char_valid,
    input wire logic                   char_stall,
    input wire b64sd_pkg::char_req_t   char_data,
    input wire logic                   result_valid,
    input wire logic                   result_stall,
    input wire b64sd_pkg::result_req_t result_data
);

    // a held-back result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result changed");

    // every accepted character yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall |=> result_valid)
    else $error("accepted character produced no result");

    // no character taken while the result slot is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> char_stall)
    else $error("character accepted over a blocked result");

    // success is only reported at end of text
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.decode_ok |-> result_data.text_done)
    else $error("decode_ok without text_done");

    // no byte value without a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.byte_valid |-> result_data.out_byte == 8'h00)
    else $error("out_byte nonzero without byte_valid");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (.*);

`default_nettype wire

@@ dv/tb_base64_stream_decoder.sv @@
`timescale 1ns / 1ps

module tb_base64_stream_decoder;

    localparam int CLK_HALF       = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 10;
    localparam int LONG_HOLD      = 150;

    logic                   clk;
    logic                   rst_n;
    logic                   char_valid;
    logic                   char_stall;
    b64sd_pkg::char_req_t   char_data;
    logic                   result_valid;
    logic                   result_stall;
    b64sd_pkg::result_req_t result_data;

    // decoder state mirror
    logic [5:0] residue   = '0;
    logic [2:0] held_bits = '0;
    logic       pad_hit   = 1'b0;
    logic       byte_made = 1'b0;

    b64sd_pkg::result_req_t decoded_q[$];
    logic [7:0]             text_buf[$];

    bit tx_no_gaps = 1'b0;
    bit rx_no_gaps = 1'b0;
    int hold_req   = 0;
    int stall_left = 0;

    int mismatches   = 0;
    int chars_sent   = 0;
    int strings_sent = 0;
    int results_seen = 0;
    int bytes_seen   = 0;
    int ok_strings   = 0;

    base64_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ascii code to 6-bit value, SEXTET_NONE outside the alphabet
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return 7'(c - 8'h41);
        end
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return 7'(c - 8'h61 + 8'd26);
        end
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 7'(c - 8'h30 + 8'd52);
        end
        if (c == 8'h2B)
        begin
            return 7'd62;
        end
        if (c == 8'h2F)
        begin
            return 7'd63;
        end
        return b64sd_pkg::SEXTET_NONE;
    endfunction

    // 6-bit value to its alphabet character, for building encoded text
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        if (v < 6'd26)
        begin
            return 8'h41 + 8'(v);
        end
        if (v < 6'd52)
        begin
            return 8'h61 + 8'(v) - 8'd26;
        end
        if (v < 6'd62)
        begin
            return 8'h30 + 8'(v) - 8'd52;
        end
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    // advance the mirror by one character and return the result it causes
    function automatic b64sd_pkg::result_req_t decode_char(input logic [7:0] c,
                                                           input logic eot);
        b64sd_pkg::result_req_t r;
        logic [6:0]             v;
        logic [11:0]            acc;
        int                     n;
        r = '0;
        if (!pad_hit)
        begin
            if (c == b64sd_pkg::PAD_CHAR)
            begin
                pad_hit = 1'b1;
            end
            else
            begin
                v = char_to_sextet(c);
                if (v != b64sd_pkg::SEXTET_NONE)
                begin
                    acc = {6'(residue & ((6'd1 << held_bits) - 6'd1)), v[5:0]};
                    n = int'(held_bits) + 6;
                    if (n >= 8)
                    begin
                        n -= 8;
                        r.out_byte   = 8'(acc >> n);
                        r.byte_valid = 1'b1;
                        byte_made    = 1'b1;
                    end
                    residue   = 6'(acc & ((12'd1 << n) - 12'd1));
                    held_bits = 3'(n);
                end
            end
        end
        r.text_done = eot;
        r.decode_ok = eot && byte_made;
        // end of text clears everything
        if (eot)
        begin
            residue   = '0;
            held_bits = '0;
            pad_hit   = 1'b0;
            byte_made = 1'b0;
        end
        return r;
    endfunction

    // one character request, then an optional idle gap
    task automatic send_char(input logic [7:0] c, input logic eot);
        int r;
        int gap;
        @(negedge clk);
        char_valid <= 1'b1;
        char_data  <= '{c, eot};
        do @(posedge clk); while (char_stall);
        decoded_q.insert(decoded_q.size(), decode_char(c, eot));
        chars_sent++;
        gap = 0;
        if (!tx_no_gaps)
        begin
            r = $urandom_range(0, 99);
            if (r >= 93)
            begin
                gap = $urandom_range(8, 30);
            end
            else if (r >= 60)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            @(negedge clk);
            char_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // append one character to the string being built
    task automatic add_char(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endtask

    task automatic push_chars(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_char(s[i]);
        end
    endtask

    // send the buffered string, end-of-text on its last character
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
        begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
        strings_sent++;
    endtask

    // sender goes quiet until every predicted result has arrived
    task automatic wait_drained();
        @(negedge clk);
        char_valid <= 1'b0;
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // mostly well-formed encoded strings, some noise and broken ones
    task automatic build_random_text();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            n = $urandom_range(2, 16);
            if (n % 4 == 1)
            begin
                n++;
            end
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    add_char(8'($urandom_range(0, 255)));
                end
                add_char(sextet_to_char(6'($urandom_range(0, 63))));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                repeat ((4 - n % 4) % 4) add_char(b64sd_pkg::PAD_CHAR);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0: add_char(sextet_to_char(6'($urandom_range(0, 63))));
                    1: add_char(b64sd_pkg::PAD_CHAR);
                    default: add_char(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    task automatic test_directed_edges();
        // alphabet boundaries, then padding, then ignored characters
        push_chars("AZaz09+/");
        add_char(b64sd_pkg::PAD_CHAR);
        push_chars("Q");
        add_char(8'hFF);
        send_text();
        // lone sextet: no byte, not ok
        push_chars("A");
        send_text();
        // byte completes on the end-of-text character
        push_chars("QQ");
        send_text();
        // all-ones byte, skipped characters, end on padding
        push_chars("//");
        add_char(8'h00);
        add_char(8'h80);
        add_char(8'h7F);
        push_chars("@[{:");
        add_char(8'h60);
        add_char(b64sd_pkg::PAD_CHAR);
        send_text();
        wait_drained();
    endtask

    task automatic test_random_strings(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at)
        begin
            build_random_text();
            send_text();
        end
    endtask

    // long receiver hold while the sender keeps offering back to back
    task automatic test_output_backpressure();
        int stop_at;
        stop_at = chars_sent + 60;
        tx_no_gaps = 1'b1;
        hold_req   = LONG_HOLD;
        while (chars_sent < stop_at)
        begin
            build_random_text();
            send_text();
        end
        tx_no_gaps = 1'b0;
    endtask

    task automatic test_drained_pauses();
        repeat (12)
        begin
            build_random_text();
            send_text();
            wait_drained();
        end
    endtask

    // no idling on either side
    task automatic test_full_rate();
        int stop_at;
        stop_at = chars_sent + 150;
        tx_no_gaps = 1'b1;
        rx_no_gaps = 1'b1;
        while (chars_sent < stop_at)
        begin
            build_random_text();
            send_text();
        end
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;
    endtask

    // receiver stall: random stretches plus requested long holds
    initial
    begin : result_sink
        int r;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            else if (stall_left == 0 && !rx_no_gaps)
            begin
                r = $urandom_range(0, 99);
                if (r >= 93)
                begin
                    stall_left = $urandom_range(8, 30);
                end
                else if (r >= 68)
                begin
                    stall_left = $urandom_range(1, 3);
                end
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // compare each result request with the oldest prediction
    always @(posedge clk)
    begin : result_check
        b64sd_pkg::result_req_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (result_data.byte_valid)
            begin
                bytes_seen++;
            end
            if (result_data.text_done && result_data.decode_ok)
            begin
                ok_strings++;
            end
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: result with nothing predicted: %p", $realtime, result_data);
                end
            end
            else
            begin
                want = decoded_q.pop_front();
                if (result_data.byte_valid !== want.byte_valid
                    || result_data.out_byte !== want.out_byte
                    || result_data.text_done !== want.text_done
                    || result_data.decode_ok !== want.decode_ok)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch expected valid=%0b byte=%02h done=%0b ok=%0b",
                                 $realtime, want.byte_valid, want.out_byte,
                                 want.text_done, want.decode_ok);
                        $display("%0t:          actual   valid=%0b byte=%02h done=%0b ok=%0b",
                                 $realtime, result_data.byte_valid, result_data.out_byte,
                                 result_data.text_done, result_data.decode_ok);
                    end
                end
            end
        end
    end

    // stop the run when no request moves on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout: no request moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, decoded_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_random_strings(500);
        test_output_backpressure();
        test_drained_pauses();
        test_full_rate();
        test_random_strings(400);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d strings, %0d characters, %0d results checked",
                 strings_sent, chars_sent, results_seen);
        $display("decoded %0d bytes, %0d strings reported ok, %0d mismatches",
                 bytes_seen, ok_strings, mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
